// ----- sv/sidd_pkg.sv -----
package sidd_pkg;

   typedef enum logic [2:0] {
      OP_ADD_PRIMARY = 3'd0,
      OP_ADD_OTHER   = 3'd1,
      OP_DIFFERENCE  = 3'd2,
      OP_MERGE       = 3'd3,
      OP_READ        = 3'd4,
      OP_CLEAR_OTHER = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_LOCKED = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RESP,
      S_SORT_INIT,
      S_SORT_LOAD,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_END,
      S_SORT_DONE,
      S_WALK_RD,
      S_WALK_CMP,
      S_COPY_RD,
      S_COPY_WR,
      S_READ_START,
      S_READ_RD,
      S_READ_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_DIFF_P,
      PH_DIFF_O,
      PH_MERGE,
      PH_READ
   } phase_type;

endpackage

// ----- sv/sorted_id_set_difference_top.sv -----
// Channel  | Dir | Beat contents
// req      | in  | tdata[63:0] id_value; tuser[2:0] opcode
// rsp      | out | tdata[63:0] out_id, [69:64] primary_count; tuser[1:0] status; tlast last
//
// Appends, clears and error replies end with a single reply beat.
// Sorting walks the list with one comparator in bubble passes, up to
// LIST_DEPTH passes; the difference walk reads, then compares, at each step.
// A read streams the entries in turn, holding while rsp is stalled. No request is taken
// until the last beat is loaded. Reset is synchronous; both lists empty, primary unlocked.
module sorted_id_set_difference_top #(
   parameter int LIST_DEPTH = 32,
   parameter int ID_WIDTH   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // id_value
   input  logic [2:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_id, primary_count, zero pad
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   logic [ID_WIDTH-1:0] p_mem [LIST_DEPTH];
   logic [ID_WIDTH-1:0] o_mem [LIST_DEPTH];

   sidd_pkg::state_type  state_ff, state_in;
   sidd_pkg::phase_type  phase_ff, phase_in;
   sidd_pkg::status_type status_ff, status_in;
   logic                 sel_ff, sel_in;
   logic                 lock_ff, lock_in;
   logic                 swap_ff, swap_in;
   logic [CW-1:0]        pu_ff, pu_in, ou_ff, ou_in;
   logic [CW-1:0]        k_ff, k_in, j_ff, j_in, n_ff, n_in;
   logic [ID_WIDTH-1:0]  carry_ff, carry_in, prev_ff, prev_in;
   logic [ID_WIDTH-1:0]  p_rd_ff, o_rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [ID_WIDTH-1:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [5:0]           rsp_count_ff, rsp_count_in;

   logic                p_we, o_we;
   logic [AW-1:0]       p_waddr, o_waddr, p_raddr, o_raddr;
   logic [ID_WIDTH-1:0] p_wdata, o_wdata;
   logic [ID_WIDTH-1:0] cmp_a, cmp_b, sort_rd;
   logic                cmp_lt, cmp_eq, out_free;
   logic [CW-1:0]       sort_n;
   logic [CW:0]         merge_sum;

   assign req_tready = (state_ff == sidd_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, 64'(rsp_id_ff)};

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign sort_n    = sel_ff ? ou_ff : pu_ff;
   assign sort_rd   = sel_ff ? o_rd_ff : p_rd_ff;
   assign merge_sum = {1'b0, pu_ff} + {1'b0, ou_ff};

   // shared comparator
   assign cmp_lt = cmp_a < cmp_b;
   assign cmp_eq = cmp_a == cmp_b;

   always_ff @(posedge clock) begin
      if (p_we) begin
         p_mem[p_waddr] <= p_wdata;
      end
      if (o_we) begin
         o_mem[o_waddr] <= o_wdata;
      end
      p_rd_ff <= p_mem[p_raddr];
      o_rd_ff <= o_mem[o_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sidd_pkg::S_IDLE;
         pu_ff        <= '0;
         ou_ff        <= '0;
         lock_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pu_ff        <= pu_in;
         ou_ff        <= ou_in;
         lock_ff      <= lock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      status_ff     <= status_in;
      sel_ff        <= sel_in;
      swap_ff       <= swap_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      carry_ff      <= carry_in;
      prev_ff       <= prev_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      status_in     = status_ff;
      sel_in        = sel_ff;
      lock_in       = lock_ff;
      swap_in       = swap_ff;
      pu_in         = pu_ff;
      ou_in         = ou_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      carry_in      = carry_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      p_we    = 1'b0;
      o_we    = 1'b0;
      p_waddr = pu_ff[AW-1:0];
      o_waddr = ou_ff[AW-1:0];
      p_wdata = req_tdata[ID_WIDTH-1:0];
      o_wdata = req_tdata[ID_WIDTH-1:0];
      p_raddr = k_ff[AW-1:0];
      o_raddr = sel_ff ? k_ff[AW-1:0] : j_ff[AW-1:0];
      cmp_a   = sort_rd;
      cmp_b   = carry_ff;

      case (state_ff)
         sidd_pkg::S_IDLE: begin
            status_in = sidd_pkg::ST_OK;
            if (req_tvalid) begin
               state_in = sidd_pkg::S_RESP;
               case (req_tuser)
                  sidd_pkg::OP_ADD_PRIMARY: begin
                     if (lock_ff) begin
                        status_in = sidd_pkg::ST_LOCKED;
                     end else if (pu_ff >= DEPTH_C) begin
                        status_in = sidd_pkg::ST_FULL;
                     end else begin
                        p_we  = 1'b1;
                        pu_in = pu_ff + 1'b1;
                     end
                  end
                  sidd_pkg::OP_ADD_OTHER: begin
                     if (ou_ff >= DEPTH_C) begin
                        status_in = sidd_pkg::ST_FULL;
                     end else begin
                        o_we  = 1'b1;
                        ou_in = ou_ff + 1'b1;
                     end
                  end
                  sidd_pkg::OP_DIFFERENCE: begin
                     if (lock_ff) begin
                        status_in = sidd_pkg::ST_LOCKED;
                     end else begin
                        phase_in = sidd_pkg::PH_DIFF_P;
                        sel_in   = 1'b0;
                        state_in = sidd_pkg::S_SORT_INIT;
                     end
                  end
                  sidd_pkg::OP_MERGE: begin
                     if (lock_ff) begin
                        status_in = sidd_pkg::ST_LOCKED;
                     end else if (merge_sum > {1'b0, DEPTH_C}) begin
                        status_in = sidd_pkg::ST_FULL;
                     end else begin
                        sel_in   = 1'b1;
                        k_in     = '0;
                        state_in = sidd_pkg::S_COPY_RD;
                     end
                  end
                  sidd_pkg::OP_READ: begin
                     if (lock_ff) begin
                        state_in = sidd_pkg::S_READ_START;
                     end else begin
                        lock_in  = 1'b1;
                        phase_in = sidd_pkg::PH_READ;
                        sel_in   = 1'b0;
                        state_in = sidd_pkg::S_SORT_INIT;
                     end
                  end
                  sidd_pkg::OP_CLEAR_OTHER: begin
                     ou_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sidd_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = 6'(pu_ff);
               state_in      = sidd_pkg::S_IDLE;
            end
         end
         // copy other list onto the tail of the primary list
         sidd_pkg::S_COPY_RD: begin
            if (k_ff == ou_ff) begin
               sel_in   = 1'b0;
               phase_in = sidd_pkg::PH_MERGE;
               state_in = sidd_pkg::S_SORT_INIT;
            end else begin
               state_in = sidd_pkg::S_COPY_WR;
            end
         end
         sidd_pkg::S_COPY_WR: begin
            p_we     = 1'b1;
            p_wdata  = o_rd_ff;
            pu_in    = pu_ff + 1'b1;
            k_in     = k_ff + 1'b1;
            state_in = sidd_pkg::S_COPY_RD;
         end
         // bubble pass: carry the larger value up the list
         sidd_pkg::S_SORT_INIT: begin
            p_raddr = '0;
            o_raddr = '0;
            k_in    = '0;
            if (sort_n < CW'(2)) begin
               state_in = sidd_pkg::S_SORT_DONE;
            end else begin
               state_in = sidd_pkg::S_SORT_LOAD;
            end
         end
         sidd_pkg::S_SORT_LOAD: begin
            carry_in = sort_rd;
            swap_in  = 1'b0;
            k_in     = CW'(1);
            state_in = sidd_pkg::S_SORT_RD;
         end
         sidd_pkg::S_SORT_RD: begin
            state_in = sidd_pkg::S_SORT_CMP;
         end
         sidd_pkg::S_SORT_CMP: begin
            p_waddr = AW'(k_ff - 1'b1);
            o_waddr = AW'(k_ff - 1'b1);
            p_wdata = cmp_lt ? sort_rd : carry_ff;
            o_wdata = p_wdata;
            p_we    = !sel_ff;
            o_we    = sel_ff;
            if (!cmp_lt) begin
               carry_in = sort_rd;
            end else begin
               swap_in = 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (k_ff + 1'b1 == sort_n) begin
               state_in = sidd_pkg::S_SORT_END;
            end else begin
               state_in = sidd_pkg::S_SORT_RD;
            end
         end
         sidd_pkg::S_SORT_END: begin
            p_waddr = AW'(sort_n - 1'b1);
            o_waddr = AW'(sort_n - 1'b1);
            p_wdata = carry_ff;
            o_wdata = carry_ff;
            p_we    = !sel_ff;
            o_we    = sel_ff;
            p_raddr = '0;
            o_raddr = '0;
            k_in    = '0;
            if (swap_ff) begin
               state_in = sidd_pkg::S_SORT_LOAD;
            end else begin
               state_in = sidd_pkg::S_SORT_DONE;
            end
         end
         sidd_pkg::S_SORT_DONE: begin
            case (phase_ff)
               sidd_pkg::PH_DIFF_P: begin
                  phase_in = sidd_pkg::PH_DIFF_O;
                  sel_in   = 1'b1;
                  state_in = sidd_pkg::S_SORT_INIT;
               end
               sidd_pkg::PH_DIFF_O: begin
                  sel_in = 1'b0;
                  k_in   = '0;
                  j_in   = '0;
                  n_in   = '0;
                  if (pu_ff == '0) begin
                     state_in = sidd_pkg::S_RESP;
                  end else begin
                     state_in = sidd_pkg::S_WALK_RD;
                  end
               end
               sidd_pkg::PH_MERGE: begin
                  state_in = sidd_pkg::S_RESP;
               end
               default: begin
                  state_in = sidd_pkg::S_READ_START;
               end
            endcase
         end
         // difference walk: k over primary, j over other, n writes back
         sidd_pkg::S_WALK_RD: begin
            state_in = sidd_pkg::S_WALK_CMP;
         end
         sidd_pkg::S_WALK_CMP: begin
            cmp_a    = o_rd_ff;
            cmp_b    = p_rd_ff;
            state_in = sidd_pkg::S_WALK_RD;
            if (j_ff < ou_ff && cmp_lt) begin
               j_in = j_ff + 1'b1;
            end else begin
               if (!(j_ff < ou_ff && cmp_eq) && (n_ff == '0 || prev_ff != p_rd_ff)) begin
                  p_we    = 1'b1;
                  p_waddr = n_ff[AW-1:0];
                  p_wdata = p_rd_ff;
                  prev_in = p_rd_ff;
                  n_in    = n_ff + 1'b1;
               end
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == pu_ff) begin
                  pu_in    = n_in;
                  state_in = sidd_pkg::S_RESP;
               end
            end
         end
         sidd_pkg::S_READ_START: begin
            k_in = '0;
            if (pu_ff == '0) begin
               status_in = sidd_pkg::ST_EMPTY;
               state_in  = sidd_pkg::S_RESP;
            end else begin
               state_in = sidd_pkg::S_READ_RD;
            end
         end
         sidd_pkg::S_READ_RD: begin
            state_in = sidd_pkg::S_READ_OUT;
         end
         sidd_pkg::S_READ_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = p_rd_ff;
               rsp_last_in   = (k_ff + 1'b1 == pu_ff);
               rsp_status_in = sidd_pkg::ST_OK;
               rsp_count_in  = 6'(pu_ff);
               k_in          = k_ff + 1'b1;
               if (k_ff + 1'b1 == pu_ff) begin
                  state_in = sidd_pkg::S_IDLE;
               end else begin
                  state_in = sidd_pkg::S_READ_RD;
               end
            end
         end
         default: begin
            state_in = sidd_pkg::S_IDLE;
         end
      endcase
   end

endmodule
